FILE: hw/rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg: shared types and constants of the sorted-array priority queue
// Transfer structs, command and status codes, parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package sapq_pkg;

  localparam int unsigned DefaultDepth     = 8;
  localparam int unsigned DefaultDataWidth = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_NOTFOUND  = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } sapq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         count;
    logic signed [31:0] top_value;
  } sapq_out_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } sapq_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell: one slot of the sorted chain
// Holds one key and compares it with the broadcast key; on an insert it takes the
// upper neighbor's key or the broadcast key, on a delete the lower neighbor's key.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_cell #(
  parameter int unsigned DATA_WIDTH = sapq_pkg::DefaultDataWidth
) (
  input  wire                          clk_i,
  input  sapq_pkg::sapq_ctrl_t         ctrl_i,
  input  wire                          valid_i,
  input  wire signed [DATA_WIDTH-1:0]  key_i,
  input  wire signed [DATA_WIDTH-1:0]  prev_entry_i,
  input  wire                          prev_ge_i,
  input  wire signed [DATA_WIDTH-1:0]  next_entry_i,
  output logic signed [DATA_WIDTH-1:0] entry_o,
  output logic                         ge_o,
  output logic                         eq_o
);
  import sapq_pkg::*;

  logic signed [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                         le;

  // invalid slots count as "key goes here" for insert
  assign ge_o = !valid_i || (key_i >= entry_q);
  assign le   = valid_i && (entry_q <= key_i);
  assign eq_o = valid_i && (entry_q == key_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && ge_o) begin
      entry_d = prev_ge_i ? prev_entry_i : key_i;
    end else if (ctrl_i.del_en && le) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_array_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core: descending sorted key store
// Chain of DEPTH cells kept in descending order; insert shifts down,
// delete of the first equal key shifts up, one status per transfer.
//
//   channel | direction | payload    | handshake
//   in      | input     | sapq_in_t  | in_valid_i / in_stall_o
//   out     | output    | sapq_out_t | out_valid_o / out_stall_i
//
// All cells compare and shift in the accept cycle; the result is shown from the
// next cycle on. One item per clock while the output is not stalled.
// Reset empties the queue (occupancy 0); cell contents need no reset.
// A stalled result holds the input off until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_priority_queue_core #(
  parameter int unsigned DEPTH      = sapq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = sapq_pkg::DefaultDataWidth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sapq_pkg::sapq_in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sapq_pkg::sapq_out_t  out_data_o
);
  import sapq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]              count_q, count_d;
  logic [1:0]                   status_q, status_d;
  logic                         out_valid_q;
  logic                         accept, full, empty, found;
  logic signed [DATA_WIDTH-1:0] key;
  sapq_ctrl_t                   ctrl;

  logic signed [DATA_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]             ge, eq, valid;

  assign key    = DATA_WIDTH'(in_data_i.value);
  assign accept = in_valid_i && !in_stall_o;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign found  = |eq;

  assign ctrl.ins_en = accept && (in_data_i.cmd == CMD_INSERT) && !full;
  assign ctrl.del_en = accept && (in_data_i.cmd == CMD_DELETE) && found;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] prev_entry, next_entry;
    logic                         prev_ge;

    assign valid[j] = (CntW'(j) < count_q);

    if (j == 0) begin : g_first
      assign prev_entry = key;
      assign prev_ge    = 1'b0;
    end else begin : g_mid
      assign prev_entry = entry[j-1];
      assign prev_ge    = ge[j-1];
    end

    if (j == DEPTH - 1) begin : g_last
      assign next_entry = entry[j];
    end else begin : g_body
      assign next_entry = entry[j+1];
    end

    sapq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid[j]),
      .key_i        (key),
      .prev_entry_i (prev_entry),
      .prev_ge_i    (prev_ge),
      .next_entry_i (next_entry),
      .entry_o      (entry[j]),
      .ge_o         (ge[j]),
      .eq_o         (eq[j])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    if (in_data_i.cmd == CMD_INSERT) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else if (!found) begin
        status_d = ST_NOTFOUND;
      end else begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign in_stall_o           = out_valid_q && out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o.status    = status_q;
  assign out_data_o.count     = 4'(count_q);
  assign out_data_o.top_value = empty ? '0 : 32'(entry[0]);

  // assertions
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy above depth");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_OVERFLOW) |-> full)
    else $error("overflow reported while not full");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow occupancy");

  for (genvar j = 0; j + 1 < DEPTH; j++) begin : g_sorted_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid[j+1] |-> entry[j] >= entry[j+1])
      else $error("chain out of order");
  end

endmodule

`default_nettype wire
